FILE: rtl/biq_pkg.sv
// Shared types, codes and constants of the binary interval quantizer.
package biq_pkg;

   // Default sizes handed to the top level parameters.
   localparam int MAX_BITS_DEF    = 32;
   localparam int VALUE_WIDTH_DEF = 32;

   // Fixed field widths.
   localparam int KIND_W    = 2;
   localparam int BITS_W    = 6;
   localparam int SETBIT_W  = 5;
   localparam int STATUS_W  = 2;
   localparam int REG_IDX_W = 2;

   typedef logic [KIND_W-1:0]    kind_type;
   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [REG_IDX_W-1:0] reg_idx_type;

   // Transaction kinds on the request channel.
   localparam kind_type KIND_ENCODE = 2'd0;
   localparam kind_type KIND_DECODE = 2'd1;
   localparam kind_type KIND_EMPTY  = 2'd2;

   // Result status codes.
   localparam status_type STATUS_OK           = 2'd0;
   localparam status_type STATUS_NOT_FITTED   = 2'd1;
   localparam status_type STATUS_OUT_OF_RANGE = 2'd2;
   localparam status_type STATUS_EMPTY_DECODE = 2'd3;

   // Configuration register indexes.
   localparam reg_idx_type REG_RANGE_LOW   = 2'd0;
   localparam reg_idx_type REG_RANGE_HIGH  = 2'd1;
   localparam reg_idx_type REG_BITS_USED   = 2'd2;
   localparam reg_idx_type REG_RANGE_VALID = 2'd3;

   localparam logic [BITS_W-1:0] BITS_USED_RESET = 6'd8;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_STEP,
      ST_FINISH
   } state_type;

   // Controls of one bisection step.
   typedef struct packed {
      logic use_cmp;   // direction from the sample compare (encode)
      logic mask_bit;  // direction from the decode mask (decode)
   } step_ctrl_type;

endpackage

FILE: rtl/biq_interfaces.sv
// Request and response channel interfaces of the binary interval quantizer.
interface biq_req_if #(
   parameter int VALUE_WIDTH = biq_pkg::VALUE_WIDTH_DEF
);
   logic                                valid;
   logic                                ready;
   logic [biq_pkg::KIND_W-1:0]          kind;
   logic signed [VALUE_WIDTH-1:0]       sample;
   logic [biq_pkg::BITS_W-1:0]          bit_index;
   logic                                last;

   modport source (output valid, kind, sample, bit_index, last, input ready);
   modport sink   (input valid, kind, sample, bit_index, last, output ready);
endinterface

interface biq_rsp_if #(
   parameter int VALUE_WIDTH = biq_pkg::VALUE_WIDTH_DEF
);
   logic                                valid;
   logic                                ready;
   logic [biq_pkg::SETBIT_W-1:0]        set_bit;
   logic                                has_bit;
   logic signed [VALUE_WIDTH-1:0]       decoded;
   logic [biq_pkg::STATUS_W-1:0]        status;
   logic                                end_of_run;

   modport source (output valid, set_bit, has_bit, decoded, status, end_of_run,
                   input ready);
   modport sink   (input valid, set_bit, has_bit, decoded, status, end_of_run,
                   output ready);
endinterface

FILE: rtl/biq_csr.sv
// Configuration registers of the binary interval quantizer behind an APB-style port.
module biq_csr #(
   parameter int MAX_BITS    = biq_pkg::MAX_BITS_DEF,
   parameter int VALUE_WIDTH = biq_pkg::VALUE_WIDTH_DEF,
   parameter int CSR_DW      = 32,
   parameter int ADDR_LSB    = 2,
   parameter int AW          = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [AW-1:0]               csr_paddr,
   input  logic [CSR_DW-1:0]           csr_pwdata,
   output logic [CSR_DW-1:0]           csr_prdata,
   output logic                        csr_pready,
   output logic [VALUE_WIDTH-1:0]      range_low,
   output logic [VALUE_WIDTH-1:0]      range_high,
   output logic [biq_pkg::BITS_W-1:0]  steps,
   output logic                        range_valid
);

   logic [VALUE_WIDTH-1:0]      range_low_ff, range_low_in;
   logic [VALUE_WIDTH-1:0]      range_high_ff, range_high_in;
   logic [biq_pkg::BITS_W-1:0]  bits_used_ff, bits_used_in;
   logic                        range_valid_ff, range_valid_in;
   biq_pkg::reg_idx_type        reg_idx;
   logic                        wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[AW-1:ADDR_LSB];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // Register write decode.
   always_comb begin
      range_low_in   = range_low_ff;
      range_high_in  = range_high_ff;
      bits_used_in   = bits_used_ff;
      range_valid_in = range_valid_ff;
      if (wr_en) begin
         unique case (reg_idx)
            biq_pkg::REG_RANGE_LOW:   range_low_in   = csr_pwdata[VALUE_WIDTH-1:0];
            biq_pkg::REG_RANGE_HIGH:  range_high_in  = csr_pwdata[VALUE_WIDTH-1:0];
            biq_pkg::REG_BITS_USED:   bits_used_in   = csr_pwdata[biq_pkg::BITS_W-1:0];
            biq_pkg::REG_RANGE_VALID: range_valid_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff   <= '0;
         range_high_ff  <= '0;
         bits_used_ff   <= biq_pkg::BITS_USED_RESET;
         range_valid_ff <= 1'b0;
      end else begin
         range_low_ff   <= range_low_in;
         range_high_ff  <= range_high_in;
         bits_used_ff   <= bits_used_in;
         range_valid_ff <= range_valid_in;
      end
   end

   // Read back the raw register contents.
   always_comb begin
      unique case (reg_idx)
         biq_pkg::REG_RANGE_LOW:   csr_prdata = CSR_DW'(range_low_ff);
         biq_pkg::REG_RANGE_HIGH:  csr_prdata = CSR_DW'(range_high_ff);
         biq_pkg::REG_BITS_USED:   csr_prdata = CSR_DW'(bits_used_ff);
         biq_pkg::REG_RANGE_VALID: csr_prdata = CSR_DW'(range_valid_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // The step count saturates at the number of steps the datapath carries.
   assign steps = (bits_used_ff > biq_pkg::BITS_W'(MAX_BITS)) ?
                  biq_pkg::BITS_W'(MAX_BITS) : bits_used_ff;

   assign range_low   = range_low_ff;
   assign range_high  = range_high_ff;
   assign range_valid = range_valid_ff;

endmodule

FILE: rtl/biq_step_unit.sv
// Shared bisection step: halve the half-width, pick a direction and move the centre.
module biq_step_unit #(
   parameter int W = 66
) (
   input  logic                   [W-1:0] acc,
   input  logic                   [W-1:0] half,
   input  logic                   [W-1:0] scaled_sample,
   input  biq_pkg::step_ctrl_type         ctrl,
   output logic                           above,
   output logic                   [W-1:0] acc_next,
   output logic                   [W-1:0] half_next
);

   logic [W-1:0] delta;

   // Halving floors toward minus infinity.
   assign delta = W'($signed(half) >>> 1);

   // Encode compares the sample to the centre; decode takes the mask bit.
   assign above = ctrl.use_cmp ? ($signed(scaled_sample) > $signed(acc)) : ctrl.mask_bit;

   assign acc_next  = above ? (acc + delta) : (acc - delta);
   assign half_next = delta;

endmodule

FILE: rtl/biq_seq.sv
// Sequencer of the binary interval quantizer: item control, step loop and result register.
module biq_seq #(
   parameter int MAX_BITS    = biq_pkg::MAX_BITS_DEF,
   parameter int VALUE_WIDTH = biq_pkg::VALUE_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   biq_req_if.sink                     req,
   biq_rsp_if.source                   rsp,
   input  logic [VALUE_WIDTH-1:0]      range_low,
   input  logic [VALUE_WIDTH-1:0]      range_high,
   input  logic [biq_pkg::BITS_W-1:0]  steps,
   input  logic                        range_valid
);

   // Centre and half-width carry MAX_BITS extra fraction bits plus headroom.
   localparam int W = VALUE_WIDTH + MAX_BITS + 2;

   biq_pkg::state_type            state_ff, state_in;
   logic                          is_dec_ff, is_dec_in;
   logic [VALUE_WIDTH-1:0]        sample_ff, sample_in;
   logic [MAX_BITS-1:0]           mask_ff, mask_in;
   logic [W-1:0]                  acc_ff, acc_in;
   logic [W-1:0]                  half_ff, half_in;
   logic [biq_pkg::BITS_W-1:0]    count_ff, count_in;
   biq_pkg::status_type           status_ff, status_in;
   logic                          pend_valid_ff, pend_valid_in;
   logic [biq_pkg::SETBIT_W-1:0]  pend_bit_ff, pend_bit_in;

   logic                          out_valid_ff, out_valid_in;
   logic [biq_pkg::SETBIT_W-1:0]  out_set_bit_ff, out_set_bit_in;
   logic                          out_has_ff, out_has_in;
   logic [VALUE_WIDTH-1:0]        out_dec_ff, out_dec_in;
   biq_pkg::status_type           out_status_ff, out_status_in;
   logic                          out_end_ff, out_end_in;

   logic                          accept;
   logic                          out_free;
   logic                          out_of_range;
   logic                          last_step;
   logic [VALUE_WIDTH:0]          span_sum, span_diff;
   logic [W-1:0]                  centre_init, half_init, scaled_sample;
   logic [MAX_BITS-1:0]           index_onehot;
   biq_pkg::step_ctrl_type        step_ctrl;
   logic                          step_above;
   logic [W-1:0]                  step_acc, step_half;

   assign req.ready = (state_ff == biq_pkg::ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign out_free  = !out_valid_ff || rsp.ready;
   assign last_step = ((count_ff + 1'b1) == steps);

   // Range check of the sample against the fitted bounds.
   assign out_of_range = ($signed(range_low) > $signed(sample_ff)) ||
                         ($signed(sample_ff) > $signed(range_high));

   // Starting centre and half-width with MAX_BITS fraction bits: bound sum and difference shifted up by MAX_BITS-1.
   assign span_sum  = {range_low[VALUE_WIDTH-1], range_low} +
                      {range_high[VALUE_WIDTH-1], range_high};
   assign span_diff = {range_high[VALUE_WIDTH-1], range_high} -
                      {range_low[VALUE_WIDTH-1], range_low};
   assign centre_init = {{(W-VALUE_WIDTH-1){span_sum[VALUE_WIDTH]}}, span_sum}
                        << (MAX_BITS - 1);
   assign half_init   = {{(W-VALUE_WIDTH-1){span_diff[VALUE_WIDTH]}}, span_diff}
                        << (MAX_BITS - 1);
   assign scaled_sample = {{2{sample_ff[VALUE_WIDTH-1]}}, sample_ff, {MAX_BITS{1'b0}}};

   // One-hot of the incoming decode index and the mask bit of the current step.
   always_comb begin
      index_onehot       = '0;
      step_ctrl.mask_bit = 1'b0;
      for (int i = 0; i < MAX_BITS; i++) begin
         index_onehot[i] = (req.bit_index == biq_pkg::BITS_W'(i));
         if (count_ff == biq_pkg::BITS_W'(i)) begin
            step_ctrl.mask_bit = mask_ff[i];
         end
      end
      step_ctrl.use_cmp = !is_dec_ff;
   end

   biq_step_unit #(
      .W (W)
   ) u_step (
      .acc           (acc_ff),
      .half          (half_ff),
      .scaled_sample (scaled_sample),
      .ctrl          (step_ctrl),
      .above         (step_above),
      .acc_next      (step_acc),
      .half_next     (step_half)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         biq_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req.kind)
                  biq_pkg::KIND_ENCODE:
                     state_in = range_valid ? biq_pkg::ST_CHECK : biq_pkg::ST_FINISH;
                  biq_pkg::KIND_DECODE: begin
                     if (req.last) begin
                        state_in = range_valid ? biq_pkg::ST_CHECK : biq_pkg::ST_FINISH;
                     end
                  end
                  biq_pkg::KIND_EMPTY:
                     state_in = biq_pkg::ST_FINISH;
                  default: ;
               endcase
            end
         end
         biq_pkg::ST_CHECK: begin
            if ((!is_dec_ff && out_of_range) || (steps == '0)) begin
               state_in = biq_pkg::ST_FINISH;
            end else begin
               state_in = biq_pkg::ST_STEP;
            end
         end
         biq_pkg::ST_STEP: begin
            if (out_free && last_step) begin
               state_in = biq_pkg::ST_FINISH;
            end
         end
         biq_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = biq_pkg::ST_IDLE;
            end
         end
         default: state_in = biq_pkg::ST_IDLE;
      endcase
   end

   // Datapath and result register updates.
   always_comb begin
      is_dec_in      = is_dec_ff;
      sample_in      = sample_ff;
      mask_in        = mask_ff;
      acc_in         = acc_ff;
      half_in        = half_ff;
      count_in       = count_ff;
      status_in      = status_ff;
      pend_valid_in  = pend_valid_ff;
      pend_bit_in    = pend_bit_ff;
      out_valid_in   = out_valid_ff && !rsp.ready;
      out_set_bit_in = out_set_bit_ff;
      out_has_in     = out_has_ff;
      out_dec_in     = out_dec_ff;
      out_status_in  = out_status_ff;
      out_end_in     = out_end_ff;

      unique case (state_ff)
         biq_pkg::ST_IDLE: begin
            if (accept) begin
               is_dec_in     = (req.kind != biq_pkg::KIND_ENCODE);
               sample_in     = req.sample;
               pend_valid_in = 1'b0;
               status_in     = range_valid ? biq_pkg::STATUS_OK : biq_pkg::STATUS_NOT_FITTED;
               if (req.kind == biq_pkg::KIND_DECODE) begin
                  mask_in = mask_ff | index_onehot;
               end
               if (req.kind == biq_pkg::KIND_EMPTY && range_valid) begin
                  status_in = biq_pkg::STATUS_EMPTY_DECODE;
               end
            end
         end
         biq_pkg::ST_CHECK: begin
            acc_in   = centre_init;
            half_in  = half_init;
            count_in = '0;
            if (!is_dec_ff && out_of_range) begin
               status_in = biq_pkg::STATUS_OUT_OF_RANGE;
            end
         end
         biq_pkg::ST_STEP: begin
            if (out_free) begin
               acc_in   = step_acc;
               half_in  = step_half;
               count_in = count_ff + 1'b1;
               // A new index pushes the previous one out as a non-final result.
               if (!is_dec_ff && step_above) begin
                  if (pend_valid_ff) begin
                     out_valid_in   = 1'b1;
                     out_set_bit_in = pend_bit_ff;
                     out_has_in     = 1'b1;
                     out_dec_in     = '0;
                     out_status_in  = biq_pkg::STATUS_OK;
                     out_end_in     = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_bit_in   = count_ff[biq_pkg::SETBIT_W-1:0];
               end
            end
         end
         biq_pkg::ST_FINISH: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_status_in  = status_ff;
               out_end_in     = 1'b1;
               out_set_bit_in = '0;
               out_has_in     = 1'b0;
               out_dec_in     = '0;
               if (is_dec_ff) begin
                  mask_in = '0;
                  if (status_ff == biq_pkg::STATUS_OK) begin
                     out_dec_in = acc_ff[MAX_BITS +: VALUE_WIDTH];
                  end
               end else if (pend_valid_ff && status_ff == biq_pkg::STATUS_OK) begin
                  out_set_bit_in = pend_bit_ff;
                  out_has_in     = 1'b1;
               end
               pend_valid_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= biq_pkg::ST_IDLE;
         mask_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mask_ff       <= mask_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      is_dec_ff      <= is_dec_in;
      sample_ff      <= sample_in;
      acc_ff         <= acc_in;
      half_ff        <= half_in;
      count_ff       <= count_in;
      status_ff      <= status_in;
      pend_bit_ff    <= pend_bit_in;
      out_set_bit_ff <= out_set_bit_in;
      out_has_ff     <= out_has_in;
      out_dec_ff     <= out_dec_in;
      out_status_ff  <= out_status_in;
      out_end_ff     <= out_end_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.set_bit    = out_set_bit_ff;
   assign rsp.has_bit    = out_has_ff;
   assign rsp.decoded    = out_dec_ff;
   assign rsp.status     = out_status_ff;
   assign rsp.end_of_run = out_end_ff;

endmodule

FILE: rtl/binary_interval_quantizer_top.sv
// Top level of the binary interval quantizer: configuration port and sequencer.
//
// Successive-approximation quantizer over a fitted range. An encode
// transaction bisects [range_low, range_high] one step per cycle while the
// output register is free, on a single shared add/subtract-and-compare unit,
// and returns one result per step whose sample lies above the centre (or
// one status result). A decode transaction that ends a list runs the same
// step loop; other decode elements give no result, and empty-list or
// status-only transactions give only a status result. The request side is
// not ready until the current transaction's last result is in the output
// register, which holds one result while the next request is taken.
// Configuration must be written only while idle; the user is bound by this,
// as the block itself leaves it unchecked.
module binary_interval_quantizer_top #(
   parameter int MAX_BITS    = biq_pkg::MAX_BITS_DEF,
   parameter int VALUE_WIDTH = biq_pkg::VALUE_WIDTH_DEF,
   localparam int CSR_DW     = (VALUE_WIDTH > 32) ? 64 : 32,
   localparam int ADDR_LSB   = $clog2(CSR_DW / 8),
   localparam int AW         = ADDR_LSB + biq_pkg::REG_IDX_W
) (
   input  logic               clock,
   input  logic               reset,
   biq_req_if.sink            req,
   biq_rsp_if.source          rsp,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [AW-1:0]      csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   output logic [CSR_DW-1:0]  csr_prdata,
   output logic               csr_pready
);

   logic [VALUE_WIDTH-1:0]      range_low;
   logic [VALUE_WIDTH-1:0]      range_high;
   logic [biq_pkg::BITS_W-1:0]  steps;
   logic                        range_valid;

   // Configuration registers.
   biq_csr #(
      .MAX_BITS    (MAX_BITS),
      .VALUE_WIDTH (VALUE_WIDTH),
      .CSR_DW      (CSR_DW),
      .ADDR_LSB    (ADDR_LSB),
      .AW          (AW)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .range_low   (range_low),
      .range_high  (range_high),
      .steps       (steps),
      .range_valid (range_valid)
   );

   // Transaction sequencer with the shared step unit.
   biq_seq #(
      .MAX_BITS    (MAX_BITS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .range_low   (range_low),
      .range_high  (range_high),
      .steps       (steps),
      .range_valid (range_valid)
   );

endmodule
